@@ rtl/itpt_pkg.sv @@
// ----------------------------------------------------------------------------
// itpt_pkg
// shared types, constants and the digit-to-ascii function for the
// integer-to-padded-text unit
// ----------------------------------------------------------------------------
package itpt_pkg;

    localparam int MAX_WIDTH_DEF = 32;

    // binary input width, decimal and hex digit counts
    localparam int BIN_W  = 64;
    localparam int NDEC   = 20;
    localparam int NHEX   = 16;
    localparam int DIG_W  = NDEC * 4;
    localparam int NDIG_W = $clog2(NDEC + 1);

    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEXL = 2'd2,
        OP_HEXU = 2'd3
    } op_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LF    = 8'h66;

    // per-item format options handed to the emitter
    typedef struct packed {
        logic left;
        logic zero;
        logic neg;
        logic upper;
    } fmt_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_NORM = 3'b010,
        E_OUT  = 3'b100
    } emit_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10)
        begin
            return CH_ZERO + {4'b0000, d};
        end
        return base + {4'b0000, d} - 8'd10;
    endfunction

endpackage

@@ rtl/itpt_dabble.sv @@
// ----------------------------------------------------------------------------
// itpt_dabble
// shift-and-add-3 binary to bcd converter, one bit per cycle
// ----------------------------------------------------------------------------
module itpt_dabble (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [itpt_pkg::BIN_W-1:0]  bin,
    output logic                        done,
    output logic [itpt_pkg::DIG_W-1:0]  bcd
);
    import itpt_pkg::*;

    localparam int CNT_W = $clog2(BIN_W);

    logic [BIN_W-1:0] bin_reg;
    logic [DIG_W-1:0] bcd_reg;
    logic [DIG_W-1:0] adj;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // add 3 to every digit of 5 or more, then shift the whole word left
    always_comb
    begin
        for (int i = 0; i < NDEC; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                         : bcd_reg[i*4 +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BIN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= bin;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            {bcd_reg, bin_reg} <= {adj[DIG_W-2:0], bin_reg, 1'b0};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

@@ rtl/itpt_emit.sv @@
// ----------------------------------------------------------------------------
// itpt_emit
// strips leading zero digits, then streams pad, sign and digit characters
// ----------------------------------------------------------------------------
module itpt_emit #(
    parameter int MAX_WIDTH = itpt_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [itpt_pkg::DIG_W-1:0]       digits,
    input  logic [itpt_pkg::NDIG_W-1:0]      ndig,
    input  itpt_pkg::fmt_t                   fmt,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   width,
    output logic                             busy,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       text_byte,
    output logic                             last
);
    import itpt_pkg::*;

    localparam int PW = $clog2(MAX_WIDTH + 1);

    emit_state_t       state_reg, state_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic [NDIG_W-1:0] ndig_reg, ndig_next;
    logic [PW-1:0]     pad_reg, pad_next;
    logic [PW-1:0]     width_reg;
    logic [PW-1:0]     len;
    logic              sign_reg, sign_next;
    fmt_t              fmt_reg;
    logic              ov_reg, ov_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [3:0]        top_dig;
    logic              slot_free;

    assign top_dig   = dig_reg[DIG_W-1 -: 4];
    assign slot_free = !ov_reg || !out_stall;
    assign len       = PW'(ndig_reg) + PW'(sign_reg);

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        ndig_next  = ndig_reg;
        pad_next   = pad_reg;
        sign_next  = sign_reg;
        ov_next    = ov_reg && out_stall;
        byte_next  = byte_reg;
        last_next  = last_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (load)
                begin
                    state_next = E_NORM;
                    dig_next   = digits;
                    ndig_next  = ndig;
                    sign_next  = fmt.neg;
                end
            end
            E_NORM:
            begin
                // drop leading zeros, keeping at least one digit
                if (top_dig == 4'd0 && ndig_reg > NDIG_W'(1))
                begin
                    dig_next  = {dig_reg[DIG_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    pad_next   = (width_reg > len) ? width_reg - len : '0;
                    state_next = E_OUT;
                end
            end
            E_OUT:
            begin
                if (slot_free)
                begin
                    if (!fmt_reg.left && pad_reg != '0)
                    begin
                        byte_next = fmt_reg.zero ? CH_ZERO : CH_SPACE;
                        pad_next  = pad_reg - 1'b1;
                    end
                    else if (sign_reg)
                    begin
                        byte_next = CH_MINUS;
                        sign_next = 1'b0;
                    end
                    else if (ndig_reg != '0)
                    begin
                        byte_next = digit_char(top_dig, fmt_reg.upper);
                        dig_next  = {dig_reg[DIG_W-5:0], 4'd0};
                        ndig_next = ndig_reg - 1'b1;
                    end
                    else
                    begin
                        byte_next = CH_SPACE;
                        pad_next  = pad_reg - 1'b1;
                    end
                    ov_next   = 1'b1;
                    last_next = (pad_next == '0) && !sign_next && (ndig_next == '0);
                    if (last_next)
                    begin
                        state_next = E_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        ndig_reg <= ndig_next;
        pad_reg  <= pad_next;
        sign_reg <= sign_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (state_reg == E_IDLE && load)
        begin
            fmt_reg   <= fmt;
            width_reg <= width;
        end
    end

    assign busy      = (state_reg != E_IDLE);
    assign out_valid = ov_reg;
    assign text_byte = byte_reg;
    assign last      = last_reg;

endmodule

@@ rtl/integer_to_padded_text_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_padded_text_unit
// formats one integer per item as a padded run of ascii characters
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): op, value, field_width, flush_left,
//   zero_pad. op selects unsigned 64-bit decimal, signed 32-bit decimal,
//   lower-case hex or upper-case hex. in_stall is high from the cycle after
//   an item is taken until the cycle after its last character has been
//   loaded into the output register; one item is in work at a time.
//   output channel (out_valid / out_stall): an item's characters one by one on
//   text_byte, with last set on the final character of the run. the output
//   register holds its character while out_stall is high and emission waits.
//   flow: decimal items pass through the bcd converter, which shifts in all
//   64 input bits and then signals done; the emitter strips up to 19 leading
//   zeros, sizes the padding, then sends max(field_width, text length)
//   characters, at most MAX_WIDTH or 20, one per cycle while out_stall is
//   low, before the input reopens. hex items load the emitter on accept and
//   strip at most 15 zeros. the bit-serial shift-add-3 converter makes
//   decimal items take longer from one accept to the next than hex ones.
//   reset clears the sequencers and the output valid; no state carries
//   between items.
// ----------------------------------------------------------------------------
module integer_to_padded_text_unit #(
    parameter int MAX_WIDTH = itpt_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [63:0] value,
    input  logic [5:0]  field_width,
    input  logic        flush_left,
    input  logic        zero_pad,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  text_byte,
    output logic        last
);
    import itpt_pkg::*;

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (PW > 6) ? PW : 6;

    state_t            state_reg, state_next;
    fmt_t              fmt_reg, fmt_in, emit_fmt;
    logic [PW-1:0]     width_reg, width_in, emit_width;
    logic [CW-1:0]     fw_ext;
    logic              accept;
    logic              is_hex;
    logic              neg_in;
    logic [31:0]       low;
    logic [BIN_W-1:0]  mag;
    logic              dab_done;
    logic [DIG_W-1:0]  dab_bcd;
    logic              emit_load;
    logic              emit_busy;
    logic [DIG_W-1:0]  emit_digits;
    logic [NDIG_W-1:0] emit_ndig;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // hex digits come straight from the nibbles, decimal goes through bcd
    assign is_hex = (op == OP_HEXL) || (op == OP_HEXU);
    assign low    = value[31:0];
    assign neg_in = (op == OP_SDEC) && low[31];
    assign mag    = (op == OP_SDEC) ? {32'b0, (neg_in ? (~low + 32'd1) : low)} : value;

    // field width saturates at MAX_WIDTH
    assign fw_ext   = CW'(field_width);
    assign width_in = (fw_ext > CW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(fw_ext);

    always_comb
    begin
        fmt_in.left  = flush_left;
        fmt_in.zero  = zero_pad;
        fmt_in.neg   = neg_in;
        fmt_in.upper = (op == OP_HEXU);
    end

    // hex items load the emitter on accept, decimal ones when bcd is ready
    assign emit_load   = (accept && is_hex) || (state_reg == S_CONV && dab_done);
    assign emit_digits = (state_reg == S_CONV) ? dab_bcd
                                               : {value, {(DIG_W - BIN_W){1'b0}}};
    assign emit_ndig   = (state_reg == S_CONV) ? NDIG_W'(NDEC) : NDIG_W'(NHEX);
    assign emit_fmt    = (state_reg == S_CONV) ? fmt_reg : fmt_in;
    assign emit_width  = (state_reg == S_CONV) ? width_reg : width_in;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_hex ? S_EMIT : S_CONV;
                end
            end
            S_CONV:
            begin
                if (dab_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fmt_reg   <= fmt_in;
            width_reg <= width_in;
        end
    end

    itpt_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && !is_hex),
        .bin   (mag),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    itpt_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .digits    (emit_digits),
        .ndig      (emit_ndig),
        .fmt       (emit_fmt),
        .width     (emit_width),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_byte (text_byte),
        .last      (last)
    );

endmodule

@@ rtl/itpt_checker.sv @@
// ----------------------------------------------------------------------------
// itpt_checker
// port-level checks for the integer-to-padded-text unit
// ----------------------------------------------------------------------------
module itpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  text_byte,
    input logic        last
);
    import itpt_pkg::*;

    // a stalled character holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(text_byte) && $stable(last))
    else $error("stalled output character changed");

    // one item at a time: the input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input still open after accepting an item");

    // only pad, sign and digit characters appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (text_byte == CH_SPACE || text_byte == CH_MINUS
                       || (text_byte >= CH_ZERO && text_byte <= CH_NINE)
                       || (text_byte >= CH_UA && text_byte <= CH_UF)
                       || (text_byte >= CH_LA && text_byte <= CH_LF)))
    else $error("unexpected output character");

    // a minus sign is never the last character of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_byte == CH_MINUS |-> !last)
    else $error("run ends on a minus sign");

endmodule

bind integer_to_padded_text_unit itpt_checker u_itpt_checker (.*);

@@ tb/sv/integer_to_padded_text_unit_tb.sv @@
// ----------------------------------------------------------------------------
// integer_to_padded_text_unit_tb
// self-checking bench for the integer-to-padded-text unit. a local predictor
// formats every accepted item into its expected run of characters; a checker
// compares each character leaving the unit, in order, against that run.
// directed items cover the value extremes, every mode and the padding rules,
// then random traffic runs under several sender-idle and receiver-stall mixes
// ----------------------------------------------------------------------------
module integer_to_padded_text_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import itpt_pkg::*;

    // widest field the unit emits, wider requests saturate to this
    localparam int FIELD_MAX    = MAX_WIDTH_DEF;
    // cycles with no handshake on either side before the run is abandoned;
    // a decimal item's conversion and stripping fit well inside it, so this is ample
    localparam int HANG_LIMIT   = 5000;
    // quiet time after the last character, longer than one item's latency
    localparam int DRAIN_CYCLES = 150;

    // one expected character of a formatted field
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  op          = OP_UDEC;
    logic [63:0] value       = '0;
    logic [5:0]  field_width = '0;
    logic        flush_left  = 1'b0;
    logic        zero_pad    = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  text_byte;
    logic        last;

    // characters still owed by the unit, oldest first
    text_char_t  expected_chars[$];
    int          error_count     = 0;
    // percent chance per cycle of the sender holding off / receiver stalling
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;

    integer_to_padded_text_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .value       (value),
        .field_width (field_width),
        .flush_left  (flush_left),
        .zero_pad    (zero_pad),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .text_byte   (text_byte),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor: builds the whole field for one item and queues it
    // ------------------------------------------------------------------------
    function automatic void predict_text(op_t mode, logic [63:0] num, logic [5:0] fw,
                                         logic left, logic zeros);
        logic [7:0]  body[$];
        logic [63:0] mag;
        logic [3:0]  nib;
        logic [7:0]  fill;
        int          width;
        int          len;
        int          total;
        int          pad;
        text_char_t  c;

        mag = num;
        // signed mode looks only at the low word, two's complement
        if (mode == OP_SDEC)
        begin
            mag = {32'd0, num[31:0]};
            if (num[31])
            begin
                mag = {32'd0, (~num[31:0]) + 32'd1};
            end
        end

        // digits are computed least significant first and pushed to the front; zero yields one '0'
        do
        begin
            if (mode == OP_UDEC || mode == OP_SDEC)
            begin
                body.push_front(CH_ZERO + 8'(mag % 64'd10));
                mag = mag / 64'd10;
            end
            else
            begin
                nib = mag[3:0];
                if (nib < 4'd10)
                    body.push_front(CH_ZERO + {4'd0, nib});
                else
                    body.push_front(((mode == OP_HEXU) ? CH_UA : CH_LA) + {4'd0, nib} - 8'd10);
                mag = mag >> 4;
            end
        end
        while (mag != 64'd0);

        if (mode == OP_SDEC && num[31])
            body.push_front(CH_MINUS);

        width = (fw > FIELD_MAX) ? FIELD_MAX : int'(fw);
        len   = body.size();
        total = (width > len) ? width : len;
        pad   = total - len;
        // zero fill only when right aligned; it lands ahead of any minus sign
        fill  = (!left && zeros) ? CH_ZERO : CH_SPACE;

        for (int k = 0; k < total; k++)
        begin
            if (left)
                c.ch = (k < len) ? body[k] : CH_SPACE;
            else
                c.ch = (k < pad) ? fill : body[k - pad];
            c.last = (k == total - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // ------------------------------------------------------------------------
    // sender: offers one item, optionally after random idle cycles, and waits
    // for it to be taken. valid is left high on acceptance so the next call
    // either replaces the payload or drops valid in that same time step
    // ------------------------------------------------------------------------
    task automatic send_number(op_t mode, logic [63:0] num, logic [5:0] fw,
                               logic left, logic zeros);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= mode;
        value       <= num;
        field_width <= fw;
        flush_left  <= left;
        zero_pad    <= zeros;
        do
            @(posedge clk);
        while (in_stall);
        predict_text(mode, num, fw, left, zeros);
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // checker: every character taken must match the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, text_byte, last);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (text_byte !== want.ch)
                begin
                    $display("%0t: text_byte mismatch: expected %h, actual %h",
                             $time, want.ch, text_byte);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: gives up after a long stretch with no handshake at all
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress, %0d characters outstanding",
                 $time, expected_chars.size());
        $display("FAIL integer_to_padded_text_unit");
        $finish;
    end

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // largest and smallest decimal values, hex all ones and zero, plus the signed boundary
    task automatic test_extreme_values();
        send_number(OP_UDEC, 64'd0, 6'd0, 1'b0, 1'b0);
        send_number(OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 1'b0, 1'b0);
        send_number(OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 1'b0, 1'b1);
        // most negative signed word
        send_number(OP_SDEC, 64'h0000_0000_8000_0000, 6'd0, 1'b0, 1'b0);
        // high word is ignored in signed mode
        send_number(OP_SDEC, 64'hFFFF_FFFF_7FFF_FFFF, 6'd0, 1'b0, 1'b0);
        send_number(OP_SDEC, 64'hA5A5_A5A5_0000_0001, 6'd3, 1'b0, 1'b0);
        send_number(OP_HEXU, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b0, 1'b1);
        send_number(OP_HEXL, 64'd0, 6'd1, 1'b1, 1'b0);
    endtask

    // one plain item per conversion mode
    task automatic test_each_mode();
        send_number(OP_UDEC, 64'd1234567890, 6'd0, 1'b0, 1'b0);
        send_number(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFD6, 6'd0, 1'b0, 1'b0);
        send_number(OP_HEXL, 64'hDEAD_BEEF_CAFE_F00D, 6'd0, 1'b0, 1'b0);
        send_number(OP_HEXU, 64'h0123_4567_89AB_CDEF, 6'd0, 1'b0, 1'b0);
    endtask

    // alignment, fill character and the width corner cases
    task automatic test_padding_rules();
        // zeros ahead of the minus sign: -5 in four columns
        send_number(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFB, 6'd4, 1'b0, 1'b1);
        send_number(OP_SDEC, 64'h0000_0000_8000_0000, 6'd20, 1'b0, 1'b1);
        // zero fill requested but left aligned: spaces instead
        send_number(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd10, 1'b1, 1'b1);
        send_number(OP_UDEC, 64'd7, 6'd32, 1'b1, 1'b0);
        send_number(OP_HEXU, 64'hF, 6'd8, 1'b0, 1'b0);
        // width equal to and below the text length
        send_number(OP_UDEC, 64'd12345, 6'd5, 1'b0, 1'b1);
        send_number(OP_HEXL, 64'hABC, 6'd2, 1'b0, 1'b0);
        // width past the limit saturates
        send_number(OP_UDEC, 64'd0, 6'd33, 1'b0, 1'b1);
        send_number(OP_HEXL, 64'h9, 6'd48, 1'b1, 1'b0);
    endtask

    // random items under a given sender/receiver mix
    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        logic [63:0] num;
        logic [5:0]  fw;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            num = {$urandom, $urandom};
            case ($urandom_range(3))
                0: ;
                // short values of every length, including near the top
                1: num = num >> $urandom_range(63);
                2: num = 64'($urandom_range(999));
                // around the signed word boundary, random high word
                default:
                    num[31:0] = $urandom_range(1) ? 32'h7FFF_FFFF - 32'($urandom_range(3))
                                                  : 32'h8000_0000 + 32'($urandom_range(3));
            endcase
            // mostly legal widths, now and then past the limit
            fw = ($urandom_range(7) == 0) ? 6'($urandom_range(63, 33))
                                          : 6'($urandom_range(32));
            send_number(op_t'($urandom_range(3)), num, fw, 1'($urandom_range(1)),
                        1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_extreme_values();
        test_each_mode();
        test_padding_rules();
        test_random_traffic(32, 0, 0);
        test_random_traffic(32, 84, 0);
        test_random_traffic(32, 0, 84);
        test_random_traffic(32, 38, 38);
        in_valid <= 1'b0;

        // let every owed character arrive, then watch for strays
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_chars.size() == 0)
            $display("PASS integer_to_padded_text_unit");
        else
            $display("FAIL integer_to_padded_text_unit");
        $finish;
    end

endmodule
